@@ hdl/bloom_filter_three_hash_macros.svh @@
// Assertion macros shared by the bloom filter modules
`ifndef BLOOM_FILTER_THREE_HASH_MACROS_SVH
`define BLOOM_FILTER_THREE_HASH_MACROS_SVH
// implication checked every cycle outside reset
`define BF_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("bloom filter check failed");
// next-cycle implication checked outside reset
`define BF_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("bloom filter check failed");
`endif

@@ hdl/bf3_pkg.sv @@
// Package: constants and types for the three-hash bloom filter
`timescale 1ns / 1ps
package bf3_pkg;
  localparam int unsigned FILTER_BITS_DEF = 65521;
  localparam logic [63:0] KNUTH_MULT = 64'd2654435761;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam int unsigned MAX_DIGITS = 20;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // request handed from the hash unit to the store controller
  typedef struct packed {
    logic        func;
    logic [23:0] idx0;
    logic [23:0] idx1;
    logic [23:0] idx2;
  } bf3_req_t;
endpackage

@@ hdl/bf3_mod.sv @@
// Reduction of a 64-bit value modulo a constant by folding the bits above IW
`timescale 1ns / 1ps
module bf3_mod
  import bf3_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
  parameter int unsigned IW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   value,
  output logic          done,
  output logic [IW-1:0] rem
);
  localparam int unsigned HW = 65 - IW;
  localparam logic [IW:0] MODV = (IW+1)'(FILTER_BITS);
  // 2^IW mod FILTER_BITS; zero when the modulus is a power of two
  localparam logic [IW-1:0] FOLD = IW'((65'd1 << IW) - 65'(FILTER_BITS));

  logic [64:0]   t;
  logic [HW-1:0] hi;
  logic [IW-1:0] lo;
  logic [64:0]   prod;
  logic [64:0]   folded;
  logic          busy;

  assign hi = t[64:IW];
  assign lo = t[IW-1:0];
  assign prod = 65'(hi) * 65'(FOLD);
  assign folded = prod + 65'(lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        t <= {1'b0, value};
      end else if (busy) begin
        if (hi == '0) begin
          // below 2^IW: one compare and subtract finishes it
          if ({1'b0, lo} >= MODV) rem <= IW'({1'b0, lo} - MODV);
          else rem <= lo;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          // replace the high part by its weight 2^IW mod FILTER_BITS
          t <= folded;
        end
      end
    end
  end
endmodule

@@ hdl/bf3_hash.sv @@
// Hash unit: decimal digits, sdbm, digit sum, multiply and three reductions
`timescale 1ns / 1ps
module bf3_hash
  import bf3_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
  parameter int unsigned IW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     func,
  input  logic [63:0] key,
  output logic     done,
  output bf3_req_t req
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_DIG = 7'b0000100, S_LEN = 7'b0001000,
    S_HASH = 7'b0010000, S_MOD = 7'b0100000, S_OUT = 7'b1000000
  } hstate_t;
  hstate_t state;

  logic [63:0] kreg, v, prod, sdbm, sum, p0, p1;
  logic [4*MAX_DIGITS-1:0] bcd, bcd_adj;
  logic [5:0]  cnt;
  logic [4:0]  n, ndig;
  logic [1:0]  mstep;
  logic [1:0]  which;
  logic        mstart, mdone;
  logic [63:0] mval;
  logic [IW-1:0] mrem;
  logic [3:0]  dig;
  logic [63:0] c;

  // add three to every digit of five or more before each shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // significant digits; zero still has one
  always_comb begin
    ndig = 5'd1;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) ndig = 5'(i + 1);
    end
  end

  assign dig = bcd[{n - 5'd1, 2'b00} +: 4];
  assign c = {56'd0, ASCII_ZERO | {4'd0, dig}};

  bf3_mod #(.FILTER_BITS(FILTER_BITS), .IW(IW)) u_mod (
    .clk(clk), .rst(rst), .start(mstart), .value(mval), .done(mdone), .rem(mrem)
  );

  always_comb begin
    case (which)
      2'd0:    mval = prod;
      2'd1:    mval = sdbm;
      default: mval = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      mstart <= 1'b0;
    end else begin
      done <= 1'b0;
      mstart <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kreg <= key;
            v <= key;
            bcd <= '0;
            cnt <= 6'd0;
            req.func <= func;
            n <= 5'd0;
            mstep <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // 64x32 product as two 32x32 partial products over cycles
          unique case (mstep)
            2'd0: begin p0 <= {32'd0, kreg[31:0]} * {32'd0, KNUTH_MULT[31:0]}; mstep <= 2'd1; end
            2'd1: begin p1 <= {32'd0, kreg[63:32]} * {32'd0, KNUTH_MULT[31:0]}; mstep <= 2'd2; end
            2'd2: begin prod <= p0 + {p1[31:0], 32'd0}; mstep <= 2'd3; end
            default: begin state <= S_DIG; end
          endcase
        end
        S_DIG: begin
          // shift the key into the BCD register, one bit per cycle
          bcd <= {bcd_adj[4*MAX_DIGITS-2:0], v[63]};
          v <= {v[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_LEN;
        end
        S_LEN: begin
          n <= ndig;
          sdbm <= '0;
          sum <= '0;
          state <= S_HASH;
        end
        S_HASH: begin
          sdbm <= c + (sdbm << 6) + (sdbm << 16) - sdbm;
          sum <= sum + c;
          n <= n - 5'd1;
          if (n == 5'd1) begin
            which <= 2'd0;
            mstart <= 1'b1;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mdone) begin
            unique case (which)
              2'd0: req.idx0 <= 24'(mrem);
              2'd1: req.idx1 <= 24'(mrem);
              default: req.idx2 <= 24'(mrem);
            endcase
            if (which == 2'd2) state <= S_OUT;
            else begin
              which <= which + 2'd1;
              mstart <= 1'b1;
            end
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/bf3_store.sv @@
// Bit store with clearing pass, set and test of three cells
`timescale 1ns / 1ps
`include "bloom_filter_three_hash_macros.svh"
module bf3_store
  import bf3_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
  parameter int unsigned IW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  bf3_req_t req,
  output logic     ready,
  output logic     done,
  output logic     hit
);
  typedef enum logic [3:0] {
    T_CLR = 4'b0001, T_IDLE = 4'b0010, T_RD = 4'b0100, T_WAIT = 4'b1000
  } tstate_t;
  tstate_t state;

  logic mem [FILTER_BITS];
  logic [IW-1:0] clr_addr, addr;
  logic we, wdata, rdata;
  logic [1:0] k;
  logic [1:0] kd;
  logic rvalid;
  logic all;
  logic func;
  bf3_req_t r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_comb begin
    we = 1'b0;
    wdata = 1'b1;
    addr = clr_addr;
    unique case (state) inside
      T_CLR: begin we = 1'b1; wdata = 1'b0; end
      T_RD, T_WAIT: begin
        case (k)
          2'd0: addr = r.idx0[IW-1:0];
          2'd1: addr = r.idx1[IW-1:0];
          default: addr = r.idx2[IW-1:0];
        endcase
        we = (func == FUNC_INSERT) && (state == T_RD);
      end
      default: ;
    endcase
  end

  assign ready = (state == T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLR;
      clr_addr <= '0;
      done <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      done <= 1'b0;
      rvalid <= 1'b0;
      unique case (state)
        T_CLR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(FILTER_BITS - 1)) state <= T_IDLE;
        end
        T_IDLE: begin
          if (start) begin
            r <= req;
            func <= req.func;
            k <= 2'd0;
            all <= 1'b1;
            state <= T_RD;
          end
        end
        T_RD: begin
          // one read per cell, each awaited in T_WAIT before the next; insert writes the same cell at once
          rvalid <= 1'b1;
          kd <= k;
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (rvalid) begin
            if (!rdata) all <= 1'b0;
            if (kd == 2'd2) begin
              hit <= all & rdata;
              done <= (func == FUNC_QUERY);
              state <= T_IDLE;
            end else begin
              k <= k + 2'd1;
              state <= T_RD;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `BF_ASSERT_IMP(a_done_query, clk, rst, done, func == FUNC_QUERY)
  `BF_ASSERT_NXT(a_start_leaves_idle, clk, rst, start && ready, !ready)
  `BF_ASSERT_IMP(a_no_write_idle, clk, rst, state == T_IDLE, !we)
endmodule

@@ hdl/bloom_filter_three_hash.sv @@
// Steps from request accept to result: multiply, BCD shift, digit count, one hash
// step per decimal digit (longer keys take more), three folding reductions, then
// the store and the output register.
// Throughput: one request at a time; the next is taken once the store is idle
// and no result is waiting.
// Reset: synchronous; a clearing pass over all FILTER_BITS cells zeros the store,
// no request is taken until it ends.
`timescale 1ns / 1ps
`include "bloom_filter_three_hash_macros.svh"
module bloom_filter_three_hash
  import bf3_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [63:0] key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        maybe_present
);
  localparam int unsigned IW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
  typedef enum logic [2:0] {
    P_IDLE = 3'b001, P_HASH = 3'b010, P_STORE = 3'b100
  } pstate_t;
  pstate_t state;
  logic hstart, hdone, sready, sdone, shit;
  bf3_req_t hreq;

  assign in_stall = !(state == P_IDLE && sready && !out_valid);
  assign hstart = in_valid && !in_stall;

  bf3_hash #(.FILTER_BITS(FILTER_BITS), .IW(IW)) u_hash (
    .clk(clk), .rst(rst), .start(hstart), .func(func), .key(key),
    .done(hdone), .req(hreq)
  );
  bf3_store #(.FILTER_BITS(FILTER_BITS), .IW(IW)) u_store (
    .clk(clk), .rst(rst), .start(hdone), .req(hreq), .ready(sready),
    .done(sdone), .hit(shit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        P_IDLE: if (hstart) state <= P_HASH;
        P_HASH: if (hdone) state <= P_STORE;
        P_STORE: begin
          if (sready && !hdone) state <= P_IDLE;
          if (sdone) begin
            out_valid <= 1'b1;
            maybe_present <= shit;
            state <= P_IDLE;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  `BF_ASSERT_IMP(a_busy_stalls, clk, rst, state != P_IDLE, in_stall)
  `BF_ASSERT_IMP(a_result_in_store, clk, rst, sdone, state == P_STORE)
  `BF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule
